>>> hw/rtl/msc_pkg.sv
// Shared types and constants for the minimum set cover table unit.
// Used by msc_ctrl, msc_dp and min_set_cover_dp_unit. No dependencies.
package msc_pkg;

  // Default sizing of the cover table
  localparam int MAX_SKILLS_DEF = 16;
  localparam int MAX_PEOPLE_DEF = 64;

  // Port field widths
  localparam int SKILL_W   = 16;   // skill_mask
  localparam int TEAM_W    = 64;   // team_mask
  localparam int SIZE_W    = 7;    // team_size, stored entry size
  localparam int S_TDATA_W = 16;   // skill_mask, byte aligned
  localparam int M_TDATA_W = 72;   // team_mask, team_size, zero fill

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int NSK_W      = 5;   // num_skills register
  localparam int NPE_W      = 7;   // num_people register

  localparam logic [CFG_IDX_W-1:0] REG_NUM_SKILLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PEOPLE = 1'd1;

  localparam logic [NSK_W-1:0] NSK_RST = 5'd16;
  localparam logic [NPE_W-1:0] NPE_RST = 7'd64;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_RD,
    ST_WAIT_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // accept the input item
    logic sweep_en;  // issue one table read-modify-write
    logic out_load;  // capture the target entry into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;   // sweep counter at entry zero
    logic item_active;  // next person still counts toward the problem
    logic item_last;    // held item carried the last flag
    logic out_free;     // output register can take a result
  } dp_stat_t;

endpackage

>>> hw/rtl/msc_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies.
module msc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports, read-before-write
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hw/rtl/msc_ctrl.sv
// Sequencer for the set cover unit: accept, table sweep, drain, result read.
// Depends on msc_pkg.
module msc_ctrl import msc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  input  logic      s_tlast,
  output logic      s_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (stat.item_active) begin
            state_next = ST_SWEEP;
          end else if (s_tlast) begin
            state_next = ST_RD;
          end
        end
      end
      ST_SWEEP: begin
        if (stat.sweep_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = stat.item_last ? ST_RD : ST_IDLE;
      end
      ST_RD: begin
        state_next = ST_WAIT_OUT;
      end
      ST_WAIT_OUT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    s_tready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.sweep_en = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_SWEEP: begin
        cmd.sweep_en = 1'b1;
      end
      ST_WAIT_OUT: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/msc_dp.sv
// Datapath for the set cover unit: config registers, person counter, cover
// table RAM with a two-stage read-modify-write, output register.
// Depends on msc_pkg and msc_ram.
module msc_dp import msc_pkg::*; #(
  parameter int MAX_SKILLS = MAX_SKILLS_DEF,
  parameter int MAX_PEOPLE = MAX_PEOPLE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata
);

  localparam int ADDR_W = MAX_SKILLS;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int PIDX_W = $clog2(MAX_PEOPLE + 1);
  localparam int WORD_W = MAX_PEOPLE + SIZE_W;

  logic [NSK_W-1:0]      num_skills;
  logic [NPE_W-1:0]      num_people;
  logic [NSK_W-1:0]      eff_skills;
  logic [PIDX_W-1:0]     eff_people;
  logic [ADDR_W-1:0]     target;
  logic [MAX_PEOPLE-1:0] full_team;
  logic [MAX_PEOPLE-1:0] pidx_bit;

  logic [PIDX_W-1:0]     pidx;
  logic [ADDR_W-1:0]     skills_q;
  logic                  last_q;
  logic                  first_q;
  logic [MAX_PEOPLE-1:0] bit_q;
  logic [ADDR_W-1:0]     cnt;

  logic                  vld1;
  logic [ADDR_W-1:0]     j_d;
  logic [ADDR_W-1:0]     src_d;

  logic [ADDR_W-1:0]     src_addr;
  logic [ADDR_W-1:0]     rd_addr_b;
  logic [WORD_W-1:0]     rd_a;
  logic [WORD_W-1:0]     rd_b;
  logic [WORD_W-1:0]     wdata;

  logic [MAX_PEOPLE-1:0] src_team;
  logic [SIZE_W-1:0]     src_size;
  logic [MAX_PEOPLE-1:0] cur_team;
  logic [SIZE_W-1:0]     cur_size;
  logic [MAX_PEOPLE-1:0] cand_team;
  logic [SIZE_W:0]       cand_size;
  logic                  take_cand;

  logic [TEAM_W-1:0]     out_team;
  logic [SIZE_W-1:0]     out_size;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_skills <= NSK_RST;
      num_people <= NPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_SKILLS: num_skills <= cfg_data[NSK_W-1:0];
        REG_NUM_PEOPLE: num_people <= cfg_data[NPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped register values
  always_comb begin
    if (num_skills > NSK_W'(MAX_SKILLS)) begin
      eff_skills = NSK_W'(MAX_SKILLS);
    end else begin
      eff_skills = num_skills;
    end
    if (num_people == '0) begin
      eff_people = PIDX_W'(1);
    end else if (num_people > NPE_W'(MAX_PEOPLE)) begin
      eff_people = PIDX_W'(MAX_PEOPLE);
    end else begin
      eff_people = num_people[PIDX_W-1:0];
    end
  end

  // Target skill mask, infeasible marker, one-hot of the person number
  always_comb begin
    for (int k = 0; k < ADDR_W; k++) begin
      target[k] = NSK_W'(k) < eff_skills;
    end
    for (int i = 0; i < MAX_PEOPLE; i++) begin
      full_team[i] = PIDX_W'(i) < eff_people;
      pidx_bit[i]  = pidx == PIDX_W'(i);
    end
  end

  // Person counter and item capture
  always_ff @(posedge clk) begin
    if (rst) begin
      pidx <= '0;
    end else if (cmd.load) begin
      if (s_tlast) begin
        pidx <= '0;
      end else if (stat.item_active) begin
        pidx <= pidx + PIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      skills_q <= s_tdata[ADDR_W-1:0] & target;
      last_q   <= s_tlast;
      first_q  <= pidx == '0;
      bit_q    <= pidx_bit;
    end
  end

  // Sweep counter, counts down from the top entry
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt <= '1;
    end else if (cmd.sweep_en) begin
      cnt <= cnt - ADDR_W'(1);
    end
  end

  assign src_addr  = cnt & ~skills_q;
  assign rd_addr_b = cmd.sweep_en ? cnt : target;

  // Stage 1 tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= cmd.sweep_en;
    end
  end

  always_ff @(posedge clk) begin
    j_d   <= cnt;
    src_d <= src_addr;
  end

  msc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (vld1),
    .waddr   (j_d),
    .wdata   (wdata),
    .raddr_a (src_addr),
    .rdata_a (rd_a),
    .raddr_b (rd_addr_b),
    .rdata_b (rd_b)
  );

  // First person of a problem sees the start pattern instead of stored data
  always_comb begin
    if (first_q) begin
      src_team = (src_d == '0) ? '0 : full_team;
      src_size = (src_d == '0) ? '0 : SIZE_W'(eff_people);
      cur_team = (j_d == '0) ? '0 : full_team;
      cur_size = (j_d == '0) ? '0 : SIZE_W'(eff_people);
    end else begin
      src_team = rd_a[MAX_PEOPLE-1:0];
      src_size = rd_a[WORD_W-1:MAX_PEOPLE];
      cur_team = rd_b[MAX_PEOPLE-1:0];
      cur_size = rd_b[WORD_W-1:MAX_PEOPLE];
    end
  end

  // Candidate team with this person; ties go to the candidate
  always_comb begin
    cand_team = src_team | bit_q;
    cand_size = {1'b0, src_size} + (((src_team & bit_q) == '0) ? (SIZE_W+1)'(1) : '0);
    take_cand = cand_size <= {1'b0, cur_size};
    wdata     = take_cand ? {cand_size[SIZE_W-1:0], cand_team} : {cur_size, cur_team};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_team <= TEAM_W'(rd_b[MAX_PEOPLE-1:0]);
      out_size <= rd_b[WORD_W-1:MAX_PEOPLE];
    end
  end

  assign m_tdata = {{(M_TDATA_W - TEAM_W - SIZE_W){1'b0}}, out_size, out_team};

  // Status
  assign stat.sweep_last  = cnt == '0;
  assign stat.item_active = pidx < eff_people;
  assign stat.item_last   = last_q;
  assign stat.out_free    = !m_tvalid || m_tready;

  // A result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending transfer");

  // Source read never hits an entry already rewritten in this sweep
  a_src_below_write: assert property (@(posedge clk) disable iff (rst)
    (vld1 && cmd.sweep_en) |-> (src_addr < j_d))
    else $error("table read overlaps entry written this sweep");

  // Person counter never passes the table width
  a_pidx_range: assert property (@(posedge clk) disable iff (rst)
    pidx <= PIDX_W'(MAX_PEOPLE))
    else $error("person counter out of range");

  // Sweep writes stop in the cycle after the last read
  a_drain_write: assert property (@(posedge clk) disable iff (rst)
    (vld1 && !cmd.sweep_en) |-> $past(cnt == '0))
    else $error("sweep ended before entry zero");

endmodule

>>> hw/rtl/min_set_cover_dp_unit.sv
// Minimum set cover unit. Each input transfer is one person's skill mask; the
// last flag closes the problem and yields one result: the smallest team (mask of
// persons) covering the low num_skills skills, with its size, or the all-persons
// mask when no cover exists. A counted person is accepted, then swept with one
// read-modify-write per cover-table entry on the table RAM, which has one write
// and two read ports, then drained. A person past num_people is only accepted.
// A result then takes a read of the table. The table needs no clearing pass after
// reset: the first person of each problem rebuilds every entry from the start
// pattern during its own sweep. Depends on msc_pkg, msc_ctrl, msc_dp and msc_ram.
module min_set_cover_dp_unit import msc_pkg::*; #(
  parameter int MAX_SKILLS = MAX_SKILLS_DEF,
  parameter int MAX_PEOPLE = MAX_PEOPLE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Person input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] skill_mask
  input  logic                  s_tlast,   // last_person
  // Team result
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata    // [63:0] team_mask, [70:64] team_size, [71] zero
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  msc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  msc_dp #(
    .MAX_SKILLS (MAX_SKILLS),
    .MAX_PEOPLE (MAX_PEOPLE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

>>> dv/tb_top.sv
// Testbench for min_set_cover_dp_unit: skill masks are streamed in as person transfers,
// and each team result is checked against a cover-table predictor kept in this module.
// Depends on msc_pkg and the min_set_cover_dp_unit RTL.
`timescale 1ns / 100ps

module tb_top;
  import msc_pkg::*;

  localparam int TBL_DEPTH = 1 << MAX_SKILLS_DEF;
  // Cycles one counted person occupies the unit (full table sweep plus accept/drain)
  localparam int SWEEP_CYC = TBL_DEPTH + 2;
  // Four times the longest honest quiet stretch: one sweep, result read, sender gap, receiver stall
  localparam int WD_LIMIT  = 4 * (SWEEP_CYC + 2 + 32 + 48);

  typedef struct {
    logic [SKILL_W-1:0] skills;
    logic               last;
  } person_t;

  typedef struct {
    logic [TEAM_W-1:0] team;
    logic [SIZE_W-1:0] size;
  } team_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // [15:0] skill_mask
  logic                  s_tlast = 1'b0; // last_person
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;        // [63:0] team_mask, [70:64] team_size, [71] zero

  min_set_cover_dp_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Cover-table predictor
  // ---------------------------------------------------------------------------
  bit [TEAM_W-1:0]   cover_team [0:TBL_DEPTH-1];
  bit [SIZE_W-1:0]   cover_size [0:TBL_DEPTH-1];
  int unsigned       person_cnt = 0;
  logic [NSK_W-1:0]  cfg_skills = NSK_RST;
  logic [NPE_W-1:0]  cfg_people = NPE_RST;

  person_t pend_q [$];   // persons waiting for the driver
  team_t   team_q [$];   // predicted teams not yet seen on the output
  int      err_cnt = 0;

  function automatic int unsigned eff_skills();
    return (cfg_skills > MAX_SKILLS_DEF) ? MAX_SKILLS_DEF : cfg_skills;
  endfunction

  function automatic int unsigned eff_people();
    if (cfg_people == 0) return 1;
    return (cfg_people > MAX_PEOPLE_DEF) ? MAX_PEOPLE_DEF : cfg_people;
  endfunction

  function automatic logic [SKILL_W-1:0] skill_target();
    logic [SKILL_W:0] t;
    t = ({{SKILL_W{1'b0}}, 1'b1} << eff_skills()) - 1'b1;
    return t[SKILL_W-1:0];
  endfunction

  // Start pattern: empty team at entry 0, infeasible marker elsewhere
  function automatic void reset_cover();
    int unsigned     n;
    logic [TEAM_W-1:0] full;
    int              j;
    n = eff_people();
    full = (n >= TEAM_W) ? '1 : ((64'd1 << n) - 64'd1);
    for (j = 0; j < TBL_DEPTH; j++) begin
      cover_team[j] = full;
      cover_size[j] = n[SIZE_W-1:0];
    end
    cover_team[0] = '0;
    cover_size[0] = '0;
  endfunction

  function automatic void predict_person(input person_t p);
    logic [SKILL_W-1:0] tgt;
    logic [SKILL_W-1:0] sk;
    logic [SKILL_W-1:0] src;
    logic [TEAM_W-1:0]  bit_i;
    logic [TEAM_W-1:0]  cand;
    logic [7:0]         csize;
    int                 j;
    team_t              r;
    tgt = skill_target();
    sk = p.skills & tgt;
    if (person_cnt == 0) reset_cover();
    if (person_cnt < eff_people()) begin
      bit_i = 64'd1 << person_cnt[5:0];
      // Descending sweep so each entry reads sources not yet updated by this person
      for (j = TBL_DEPTH - 1; j >= 0; j--) begin
        src = j[SKILL_W-1:0] & ~sk;
        cand = cover_team[src] | bit_i;
        csize = {1'b0, cover_size[src]} + (((cover_team[src] & bit_i) != 0) ? 8'd0 : 8'd1);
        if (csize <= {1'b0, cover_size[j]}) begin
          cover_team[j] = cand;
          cover_size[j] = csize[SIZE_W-1:0];
        end
      end
      person_cnt++;
    end
    if (p.last) begin
      r.team = cover_team[tgt];
      r.size = cover_size[tgt];
      team_q.push_back(r);
      person_cnt = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of transfers with random gaps
  // ---------------------------------------------------------------------------
  person_t drv_item;
  int      burst_left = 0;
  int      gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!s_tvalid || s_tready) begin
      // transfer of the held person completes at this edge
      if (s_tvalid) predict_person(drv_item);
      if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pend_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else begin
        drv_item = pend_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= drv_item.skills;
        s_tlast <= drv_item.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern and result checker
  // ---------------------------------------------------------------------------
  int rdy_left = 0;
  int rdy_mode = 1;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rdy_left = 0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode = $urandom_range(0, 3);
        rdy_left = $urandom_range(1, 48);
      end else begin
        rdy_left--;
      end
      case (rdy_mode)
        0: begin
          m_tready <= 1'b0;
        end
        2: begin
          m_tready <= ~m_tready;
        end
        default: begin
          m_tready <= 1'b1;
        end
      endcase
    end
  end

  always @(posedge clk) begin : chk
    team_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (team_q.size() == 0) begin
        if (err_cnt < 10) $display("unexpected team result: tdata %h", m_tdata);
        err_cnt++;
      end else begin
        want = team_q.pop_front();
        if (m_tdata[TEAM_W-1:0] !== want.team ||
            m_tdata[TEAM_W +: SIZE_W] !== want.size) begin
          if (err_cnt < 10)
            $display("team mismatch: mask exp %h got %h, size exp %0d got %0d",
                     want.team, m_tdata[TEAM_W-1:0], want.size, m_tdata[TEAM_W +: SIZE_W]);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int unsigned gen_pi = 0;     // person index of the problem being queued
  int          counted = 0;    // persons queued that the unit will sweep
  logic        ended_open = 1'b0;

  // Both registers, written back to back while the unit is idle
  task automatic set_config(input logic [CFG_DATA_W-1:0] nsk_raw,
                            input logic [CFG_DATA_W-1:0] npe_raw);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_NUM_SKILLS;
    cfg_data <= nsk_raw;
    @(posedge clk);
    cfg_index <= REG_NUM_PEOPLE;
    cfg_data <= npe_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_skills = nsk_raw[NSK_W-1:0];
    cfg_people = npe_raw[NPE_W-1:0];
    @(negedge clk);
  endtask

  task automatic queue_person(input logic [SKILL_W-1:0] sk, input logic lst);
    person_t p;
    p.skills = sk;
    p.last = lst;
    pend_q.push_back(p);
    if (gen_pi < eff_people()) begin
      gen_pi++;
      counted++;
    end
    if (lst) gen_pi = 0;
    ended_open = !lst;
  endtask

  // Sender holds off until everything queued is through and every team has come back
  task automatic wait_idle();
    while (pend_q.size() != 0 || s_tvalid || team_q.size() != 0) @(negedge clk);
    // an open problem may still be sweeping its last person
    repeat (ended_open ? SWEEP_CYC + 16 : 8) @(negedge clk);
  endtask

  function automatic logic [SKILL_W-1:0] rand_skills();
    logic [SKILL_W-1:0] tgt;
    tgt = skill_target();
    case ($urandom_range(0, 5))
      0: return SKILL_W'($urandom);
      1: return SKILL_W'($urandom & $urandom);
      2: return 16'd1 << $urandom_range(0, SKILL_W - 1);
      3: return tgt & SKILL_W'($urandom & $urandom);
      4: return SKILL_W'(~($urandom & $urandom));
      default: return tgt;
    endcase
  endfunction

  initial begin
    int               nprob;
    int               k;
    logic [NSK_W-1:0] nsk;
    logic [NPE_W-1:0] npe;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: single full-skill person, split cover, no cover, edge bits
    queue_person(16'hFFFF, 1'b1);
    queue_person(16'h00FF, 1'b0);
    queue_person(16'hFF00, 1'b0);
    queue_person(16'h0F0F, 1'b1);
    queue_person(16'h0000, 1'b1);
    queue_person(16'h8001, 1'b0);
    queue_person(16'h7FFE, 1'b1);
    wait_idle();

    // No skills in use, zero people acts as one
    set_config(7'd0, 7'd0);
    queue_person(16'hFFFF, 1'b1);
    wait_idle();

    // Four skills, two people: extra skill bits, too many persons, no cover
    set_config(7'h64, 7'd2);
    queue_person(16'h0003, 1'b0);
    queue_person(16'hFFFC, 1'b0);
    queue_person(16'h000F, 1'b1);
    queue_person(16'h0001, 1'b0);
    queue_person(16'h0002, 1'b1);
    wait_idle();

    // Registers above their maxima
    set_config(7'h7F, 7'd127);
    queue_person(16'hFFFF, 1'b1);
    queue_person(16'h5555, 1'b0);
    queue_person(16'hAAAA, 1'b1);
    wait_idle();

    // Configuration change in the middle of a problem
    set_config(7'd1, 7'd3);
    queue_person(16'h0000, 1'b0);
    wait_idle();
    set_config(7'd2, 7'd3);
    queue_person(16'h0002, 1'b1);
    wait_idle();

    // Random phases: mostly small teams, settings swept across their range
    while (counted < 95) begin
      case ($urandom_range(0, 7))
        0: nsk = 5'd0;
        1: nsk = 5'd1;
        2: nsk = 5'd16;
        3: nsk = NSK_W'($urandom_range(17, 31));
        default: nsk = NSK_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 7))
        0: npe = 7'd0;
        1: npe = 7'd1;
        2: npe = 7'd64;
        3: npe = NPE_W'($urandom_range(65, 127));
        default: npe = NPE_W'($urandom_range(1, 6));
      endcase
      set_config({2'($urandom_range(0, 3)), nsk}, npe);
      nprob = $urandom_range(1, 4);
      repeat (nprob) begin
        k = $urandom_range(1, 4);
        repeat (k - 1) queue_person(rand_skills(), 1'b0);
        queue_person(rand_skills(), 1'b1);
      end
      // sometimes leave a problem open across the next register change
      if ($urandom_range(0, 7) == 0) queue_person(rand_skills(), 1'b0);
      wait_idle();
    end

    // Close any open problem, then let the unit drain
    if (ended_open) queue_person(rand_skills(), 1'b1);
    while (pend_q.size() != 0 || s_tvalid || team_q.size() != 0) @(negedge clk);
    repeat (SWEEP_CYC + 16) @(negedge clk);

    if (err_cnt == 0 && team_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
